// ----- design/utf8_stream_decoder_top_defines.svh -----
// Assertion macros for the UTF-8 stream decoder top level
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define U8SD_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("u8sd assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define U8SD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("u8sd assertion failed");

`endif

// ----- design/u8sd_pkg.sv -----
// Types, constants and codes shared by the UTF-8 stream decoder modules
`timescale 1ns / 1ps

package u8sd_pkg;

    // Width of a decoded code point
    localparam int CP_W = 21;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEQ  = 2'd1,
        PH_BARE = 2'd2
    } t_phase;

    // Code point limits
    localparam logic [CP_W-1:0] CP_REPL    = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MIN     = 21'h0000A0;
    localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;

    // Byte class masks and tags
    localparam logic [7:0] MASK_2 = 8'hC0;
    localparam logic [7:0] TAG_CONT = 8'h80;
    localparam logic [7:0] MASK_3 = 8'hE0;
    localparam logic [7:0] TAG_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_4 = 8'hF0;
    localparam logic [7:0] TAG_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_5 = 8'hF8;
    localparam logic [7:0] TAG_LEAD4 = 8'hF0;
    localparam logic [5:0] CONT_BITS = 6'h3F;

    // Sequence lengths
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    // Results produced by one input byte
    typedef logic [1:0] t_count;
    localparam t_count CNT_NONE = 2'd0;
    localparam t_count CNT_ONE  = 2'd1;
    localparam t_count CNT_TWO  = 2'd2;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
        logic            eos;
    } t_result;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_beat;

    typedef struct packed {
        t_phase          phase;
        logic [2:0]      seq_len;
        logic [1:0]      rem;
        logic [CP_W-1:0] acc;
    } t_dec_state;

    typedef struct packed {
        logic       emit;
        t_result    res;
        t_dec_state st;
    } t_start;

    // Status from the output buffer to the top level
    typedef struct packed {
        logic can_load;
        logic spare_valid;
    } t_buf_status;

    localparam t_dec_state DEC_IDLE = '{phase: PH_IDLE, seq_len: '0, rem: '0, acc: '0};

endpackage

// ----- design/u8sd_decode.sv -----
// Decoder state registers and single-pass byte decode logic
`timescale 1ns / 1ps

module u8sd_decode
    import u8sd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    output t_count     o_count,
    output t_result    o_res0,
    output t_result    o_res1
);

    t_dec_state r_state;
    t_dec_state n_state;

    // Decode a byte that does not continue an open sequence
    function automatic t_start start_byte(input logic [7:0] b, input logic in_bare);
        t_start s;
        s.emit = 1'b0;
        s.res  = '0;
        s.st   = DEC_IDLE;
        if (b == 8'h00) begin
            s.emit    = 1'b1;
            s.res.eos = 1'b1;
        end else if (!b[7]) begin
            s.emit   = 1'b1;
            s.res.cp = {{(CP_W-8){1'b0}}, b};
        end else if ((b & MASK_2) == TAG_CONT) begin
            s.emit     = !in_bare;
            s.res.cp   = CP_REPL;
            s.res.repl = 1'b1;
            s.st.phase = PH_BARE;
        end else if ((b & MASK_3) == TAG_LEAD2) begin
            s.st.phase   = PH_SEQ;
            s.st.seq_len = LEN_2;
            s.st.rem     = 2'd1;
            s.st.acc     = {{(CP_W-5){1'b0}}, b[4:0]};
        end else if ((b & MASK_4) == TAG_LEAD3) begin
            s.st.phase   = PH_SEQ;
            s.st.seq_len = LEN_3;
            s.st.rem     = 2'd2;
            s.st.acc     = {{(CP_W-4){1'b0}}, b[3:0]};
        end else if ((b & MASK_5) == TAG_LEAD4) begin
            s.st.phase   = PH_SEQ;
            s.st.seq_len = LEN_4;
            s.st.rem     = 2'd3;
            s.st.acc     = {{(CP_W-3){1'b0}}, b[2:0]};
        end else begin
            s.emit     = 1'b1;
            s.res.cp   = CP_REPL;
            s.res.repl = 1'b1;
        end
        return s;
    endfunction

    // Out-of-range, surrogate or overlong value
    function automatic logic value_bad(input logic [CP_W-1:0] c, input logic [2:0] len);
        logic bad;
        bad = (c < CP_MIN) || ((c >= CP_SURR_LO) && (c <= CP_SURR_HI)) ||
              ((len == LEN_3) && (c < CP_MIN3)) || ((len == LEN_4) && (c < CP_MIN4)) ||
              (c > CP_MAX);
        return bad;
    endfunction

    t_start          w_start;
    logic [CP_W-1:0] w_acc;
    logic [1:0]      w_rem;
    t_result         w_repl;

    // Next state and results for the byte in the input register
    always_comb begin
        w_start = start_byte(i_byte, r_state.phase == PH_BARE);
        w_acc   = {r_state.acc[CP_W-7:0], i_byte[5:0] & CONT_BITS};
        w_rem   = r_state.rem - 2'd1;
        w_repl  = '{cp: CP_REPL, repl: 1'b1, eos: 1'b0};
        n_state = r_state;
        o_count = CNT_NONE;
        o_res0  = '0;
        o_res1  = '0;
        case (r_state.phase)
            PH_SEQ: begin
                if ((i_byte & MASK_2) == TAG_CONT) begin
                    if (w_rem == 2'd0) begin
                        n_state = DEC_IDLE;
                        o_count = CNT_ONE;
                        if (value_bad(w_acc, r_state.seq_len)) begin
                            o_res0 = w_repl;
                        end else begin
                            o_res0 = '{cp: w_acc, repl: 1'b0, eos: 1'b0};
                        end
                    end else begin
                        n_state.acc = w_acc;
                        n_state.rem = w_rem;
                    end
                end else begin
                    // interrupted sequence, then decode the byte as a new start
                    n_state = w_start.st;
                    o_res0  = w_repl;
                    o_res1  = w_start.res;
                    o_count = w_start.emit ? CNT_TWO : CNT_ONE;
                end
            end
            default: begin
                n_state = w_start.st;
                o_res0  = w_start.res;
                o_count = w_start.emit ? CNT_ONE : CNT_NONE;
            end
        endcase
    end

    // State register, advances once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DEC_IDLE;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/u8sd_out_buf.sv -----
// Result register plus one spare entry for the second result of a byte
`timescale 1ns / 1ps

module u8sd_out_buf
    import u8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_count      i_count,
    input  t_result     i_res0,
    input  t_result     i_res1,
    input  logic        i_ready,
    output logic        o_valid,
    output t_beat       o_beat,
    output t_buf_status o_status
);

    logic  r_out_v;
    logic  r_spare_v;
    t_beat r_out;
    t_beat r_spare;
    logic  n_out_v;
    logic  n_spare_v;
    t_beat n_out;
    t_beat n_spare;
    logic  w_taken;
    logic  w_can_load;

    assign w_taken    = r_out_v && i_ready;
    assign w_can_load = !r_spare_v && (!r_out_v || i_ready);

    // Next contents: load the results of a new byte, or shift the spare forward
    always_comb begin
        n_out_v   = r_out_v;
        n_spare_v = r_spare_v;
        n_out     = r_out;
        n_spare   = r_spare;
        if (w_can_load && i_load) begin
            n_out_v   = 1'b0;
            n_spare_v = 1'b0;
            case (i_count)
                CNT_ONE: begin
                    n_out_v = 1'b1;
                    n_out   = '{res: i_res0, last: 1'b1};
                end
                CNT_TWO: begin
                    n_out_v   = 1'b1;
                    n_out     = '{res: i_res0, last: 1'b0};
                    n_spare_v = 1'b1;
                    n_spare   = '{res: i_res1, last: 1'b1};
                end
                default: begin
                    n_out_v = 1'b0;
                end
            endcase
        end else if (w_taken) begin
            n_out_v   = r_spare_v;
            n_out     = r_spare;
            n_spare_v = 1'b0;
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v   <= 1'b0;
            r_spare_v <= 1'b0;
        end else begin
            r_out_v   <= n_out_v;
            r_spare_v <= n_spare_v;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_spare <= n_spare;
    end

    assign o_valid  = r_out_v;
    assign o_beat   = r_out;
    assign o_status = '{can_load: w_can_load, spare_valid: r_spare_v};

endmodule

// ----- design/utf8_stream_decoder_top.sv -----
// UTF-8 stream decoder: top level with input register and output buffer
//
// Slave channel takes one UTF-8 byte per transaction on i_s_tdata; a zero
// byte ends the string. Master channel gives decoded code points: tdata holds
// the 21-bit code point, tuser bit 0 flags a substituted U+FFFD, tuser bit 1
// flags the end-of-string marker, tlast marks the last result of a byte.
// A byte yields zero, one or two results.
// A byte is held in the input register, then decoded into the output register
// once the output buffer can take its results; the receiver takes it there.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver is ready; after a byte with two results the next one waits
// until the spare entry empties, since the result register plus its one spare
// entry is the only output path.
// Reset (synchronous, active low) empties both stages and puts the decoder
// in the idle phase; no clearing pass is needed.
// When the receiver stalls, the result register and spare hold, the input
// register fills, and o_s_tready drops until the output moves again.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top
    import u8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  o_m_tuser,   // [0] is_replacement, [1] end_of_string
    output logic        o_m_tlast    // last_of_run
);

    logic        r_in_v;
    logic [7:0]  r_in_byte;
    logic        w_adv;
    t_count      w_count;
    t_result     w_res0;
    t_result     w_res1;
    t_beat       w_beat;
    t_buf_status w_status;

    // Decode the held byte when the output buffer can take its results
    assign w_adv      = r_in_v && w_status.can_load;
    assign o_s_tready = !r_in_v || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_v <= 1'b1;
        end else if (w_adv) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    u8sd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_byte),
        .o_count (w_count),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    u8sd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_count  (w_count),
        .i_res0   (w_res0),
        .i_res1   (w_res1),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_beat   (w_beat),
        .o_status (w_status)
    );

    // Output packing
    assign o_m_tdata = {{(24-CP_W){1'b0}}, w_beat.res.cp};
    assign o_m_tuser = {w_beat.res.eos, w_beat.res.repl};
    assign o_m_tlast = w_beat.last;

    // A result that is not the last of its byte always has its partner waiting
    `U8SD_ASSERT_NOW(a_pair_held, i_clk, i_rst_n,
        o_m_tvalid && !o_m_tlast, w_status.spare_valid)
    // The end marker is the final result of its byte and carries code point zero
    `U8SD_ASSERT_NOW(a_eos_form, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser[1], o_m_tlast && !o_m_tuser[0] && (o_m_tdata == '0))
    // Substituted results carry U+FFFD
    `U8SD_ASSERT_NOW(a_repl_value, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser[0], o_m_tdata[CP_W-1:0] == CP_REPL)
    // A stalled pair keeps the spare entry filled
    `U8SD_ASSERT_NEXT(a_spare_kept, i_clk, i_rst_n,
        w_status.spare_valid && !i_m_tready, w_status.spare_valid && o_m_tvalid)

endmodule

// ----- dv/utf8_stream_decoder_top_tb.sv -----
// Self-checking testbench for the UTF-8 stream decoder: bursty byte driver, stalling receiver
`timescale 1ns / 1ps

module utf8_stream_decoder_top_tb;
    import u8sd_pkg::*;

    localparam int RANDOM_BYTES = 1600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 100;

    // Receiver stall patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } t_ready_mode;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] in_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;            // [20:0] code_point, [23:21] zero
    logic [1:0]  o_m_tuser;            // [0] is_replacement, [1] end_of_string
    logic        o_m_tlast;            // last_of_run

    // Byte stream waiting to be driven, decoded results still owed by the DUT
    logic [7:0] byte_q[$];
    t_beat      cp_expect_q[$];

    // Shadow decoder state
    t_phase          dec_phase = PH_IDLE;
    logic [2:0]      dec_len   = '0;
    logic [1:0]      dec_left  = '0;
    logic [CP_W-1:0] dec_acc   = '0;

    // Results of the byte being predicted
    t_beat cp_step_res[2];
    int    cp_step_n;

    int          mismatch_cnt = 0;
    int          bytes_total  = 0;
    int          bytes_taken  = 0;
    int          gap_left     = 0;
    int          burst_left   = 1;
    int          stall_tick   = 0;
    int          cycle_cnt    = 0;
    t_ready_mode ready_mode   = RDY_ALWAYS;

    utf8_stream_decoder_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Decoder prediction
    // ---------------------------------------------------------------

    task automatic add_cp_result(input logic [CP_W-1:0] cp, input logic repl, input logic eos);
        cp_step_res[cp_step_n].res.cp   = cp;
        cp_step_res[cp_step_n].res.repl = repl;
        cp_step_res[cp_step_n].res.eos  = eos;
        cp_step_res[cp_step_n].last     = 1'b0;
        cp_step_n++;
    endtask

    task automatic clear_decoder();
        dec_phase = PH_IDLE;
        dec_len   = '0;
        dec_left  = '0;
        dec_acc   = '0;
    endtask

    function automatic logic cp_rejected(input logic [CP_W-1:0] c, input logic [2:0] len);
        if (c < CP_MIN) return 1'b1;
        if (c >= CP_SURR_LO && c <= CP_SURR_HI) return 1'b1;
        if (len == LEN_3 && c < CP_MIN3) return 1'b1;
        if (len == LEN_4 && c < CP_MIN4) return 1'b1;
        return c > CP_MAX;
    endfunction

    // A byte seen outside an open sequence
    task automatic open_from_byte(input logic [7:0] b, input logic in_bare);
        if (b == 8'h00) begin
            clear_decoder();
            add_cp_result('0, 1'b0, 1'b1);
        end else if (!b[7]) begin
            clear_decoder();
            add_cp_result(CP_W'(b), 1'b0, 1'b0);
        end else if ((b & MASK_2) == TAG_CONT) begin
            // only the first byte of a bare run is reported
            if (!in_bare) add_cp_result(CP_REPL, 1'b1, 1'b0);
            clear_decoder();
            dec_phase = PH_BARE;
        end else if ((b & MASK_3) == TAG_LEAD2) begin
            dec_phase = PH_SEQ;
            dec_len   = LEN_2;
            dec_left  = 2'd1;
            dec_acc   = CP_W'(b[4:0]);
        end else if ((b & MASK_4) == TAG_LEAD3) begin
            dec_phase = PH_SEQ;
            dec_len   = LEN_3;
            dec_left  = 2'd2;
            dec_acc   = CP_W'(b[3:0]);
        end else if ((b & MASK_5) == TAG_LEAD4) begin
            dec_phase = PH_SEQ;
            dec_len   = LEN_4;
            dec_left  = 2'd3;
            dec_acc   = CP_W'(b[2:0]);
        end else begin
            clear_decoder();
            add_cp_result(CP_REPL, 1'b1, 1'b0);
        end
    endtask

    // Advance the shadow decoder by one byte and queue what it emits
    task automatic decode_utf8_byte(input logic [7:0] b);
        logic [CP_W-1:0] value;
        logic [2:0]      len;
        cp_step_n = 0;
        if (dec_phase == PH_SEQ) begin
            if ((b & MASK_2) == TAG_CONT) begin
                dec_acc  = {dec_acc[CP_W-7:0], b[5:0] & CONT_BITS};
                dec_left = dec_left - 2'd1;
                if (dec_left == 2'd0) begin
                    value = dec_acc;
                    len   = dec_len;
                    clear_decoder();
                    if (cp_rejected(value, len)) add_cp_result(CP_REPL, 1'b1, 1'b0);
                    else add_cp_result(value, 1'b0, 1'b0);
                end
            end else begin
                // interrupted sequence, then the byte starts over
                add_cp_result(CP_REPL, 1'b1, 1'b0);
                clear_decoder();
                open_from_byte(b, 1'b0);
            end
        end else begin
            open_from_byte(b, dec_phase == PH_BARE);
        end
        if (cp_step_n > 0) cp_step_res[cp_step_n-1].last = 1'b1;
        for (int k = 0; k < cp_step_n; k++) cp_expect_q = {cp_expect_q, cp_step_res[k]};
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Append one byte to the pending stream
    task automatic add_byte(input logic [7:0] b);
        byte_q = {byte_q, b};
    endtask

    task automatic push_cont();
        add_byte(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    // Encode cp as a len-byte sequence, overlong or out of range included
    task automatic push_encoded(input int len, input logic [CP_W-1:0] cp);
        case (len)
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic push_sequence(input int len);
        logic [CP_W-1:0] cp;
        if ($urandom_range(0, 1) == 0) begin
            // raw lead with random continuation bytes
            case (len)
                2:       add_byte(8'($urandom_range(8'hC0, 8'hDF)));
                3:       add_byte(8'($urandom_range(8'hE0, 8'hEF)));
                default: add_byte(8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            for (int k = 1; k < len; k++) push_cont();
        end else begin
            case (len)
                2: cp = CP_W'($urandom_range(0, 'h7FF));
                3: cp = ($urandom_range(0, 5) == 0) ? CP_W'($urandom_range('hD7F0, 'hE00F))
                                                    : CP_W'($urandom_range(0, 'hFFFF));
                default: begin
                    case ($urandom_range(0, 3))
                        0:       cp = CP_W'($urandom_range('h10FFF0, 'h11000F));
                        1:       cp = CP_W'($urandom_range('hFFF0, 'h1000F));
                        default: cp = CP_W'($urandom_range(0, 'h1FFFFF));
                    endcase
                end
            endcase
            push_encoded(len, cp);
        end
    endtask

    task automatic fill_stimulus();
        logic [7:0] directed[] = '{
            8'h01, 8'h7F,                  // ASCII extremes
            8'hC2, 8'hA0,                  // smallest accepted value
            8'hE0, 8'h9F, 8'hBF,           // overlong three-byte form
            8'hED, 8'hA0, 8'h80,           // surrogate
            8'hF4, 8'h90, 8'h80, 8'h80,    // above the Unicode range
            8'h80, 8'hBF,                  // bare continuation run
            8'hF8, 8'hFF,                  // invalid leads
            8'hE2, 8'h41,                  // sequence cut by ASCII
            8'hC3, 8'h00,                  // sequence cut by end of string
            8'h00,                         // end of string while idle
            8'h80, 8'h00                   // bare run closed by end of string
        };
        int kind;
        int len;
        foreach (directed[k]) add_byte(directed[k]);
        while (byte_q.size() < directed.size() + RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 24) begin
                add_byte(8'($urandom_range(1, 127)));
            end else if (kind < 44) begin
                push_sequence(2);
            end else if (kind < 64) begin
                push_sequence(3);
            end else if (kind < 80) begin
                push_sequence(4);
            end else if (kind < 85) begin
                add_byte(8'h00);
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 4)) push_cont();
            end else if (kind < 94) begin
                add_byte(8'($urandom_range(8'hF8, 8'hFF)));
            end else begin
                // truncated sequence; a following byte that is not a continuation interrupts it
                len = $urandom_range(2, 4);
                case (len)
                    2:       add_byte(8'($urandom_range(8'hC0, 8'hDF)));
                    3:       add_byte(8'($urandom_range(8'hE0, 8'hEF)));
                    default: add_byte(8'($urandom_range(8'hF0, 8'hF7)));
                endcase
                repeat ($urandom_range(0, len - 2)) push_cont();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Byte driver: bursts with random gaps
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : byte_driver
        logic       valid_n;
        logic [7:0] data_n;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                decode_utf8_byte(i_s_tdata);
                bytes_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                valid_n = 1'b0;
                data_n  = i_s_tdata;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (byte_q.size() != 0) begin
                    valid_n = 1'b1;
                    data_n  = byte_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                                 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                i_s_tvalid <= valid_n;
                i_s_tdata  <= data_n;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and receiver stalls
    // ---------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
        if (mismatch_cnt < MAX_REPORTS)
            $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_beat want;
        logic  ready_n;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (cp_expect_q.size() == 0) begin
                    flag_mismatch("unexpected result, tdata", o_m_tdata, '0);
                end else begin
                    want = cp_expect_q.pop_front();
                    if (o_m_tdata !== {3'b000, want.res.cp})
                        flag_mismatch("code point", o_m_tdata, {3'b000, want.res.cp});
                    if (o_m_tuser[0] !== want.res.repl)
                        flag_mismatch("replacement flag", 24'(o_m_tuser[0]), 24'(want.res.repl));
                    if (o_m_tuser[1] !== want.res.eos)
                        flag_mismatch("end of string flag", 24'(o_m_tuser[1]), 24'(want.res.eos));
                    if (o_m_tlast !== want.last)
                        flag_mismatch("tlast", 24'(o_m_tlast), 24'(want.last));
                end
            end
            // periodically pick a new stall pattern at random
            stall_tick++;
            if (stall_tick % 128 == 0) ready_mode = t_ready_mode'($urandom_range(0, 3));
            case (ready_mode)
                RDY_ALWAYS: ready_n = 1'b1;
                RDY_COIN:   ready_n = 1'($urandom_range(0, 1));
                RDY_SPARSE: ready_n = ($urandom_range(0, 3) == 0);
                default:    ready_n = (stall_tick % 5) < 3;
            endcase
            i_m_tready <= ready_n;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, run, drain, verdict
    // ---------------------------------------------------------------

    initial begin
        fill_stimulus();
        bytes_total = byte_q.size();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (bytes_taken < bytes_total) @(posedge i_clk);
        while (cp_expect_q.size() != 0) @(posedge i_clk);
        // catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
